// File: design/acr_pkg.sv
`timescale 1ns / 1ps

package acr_pkg;

    // Field widths of the channels
    localparam int unsigned START_W = 32;
    localparam int unsigned COUNT_W = 31;
    localparam int unsigned PADDR_W = 32;
    localparam int unsigned PLEN_W  = 6;

    // Most prefixes emitted for one range
    localparam int unsigned RESULT_LIMIT = 62;
    localparam int unsigned RCNT_W       = 6;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_STEP
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // take a new range
        logic calc;   // size the next block
        logic step;   // emit prefix and advance
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic count_zero;  // incoming range is empty
        logic slot_free;   // output register can take a prefix
        logic final_step;  // prefix being emitted ends the run
    } dp_status_t;

endpackage

// File: design/acr_req_if.sv
`timescale 1ns / 1ps

interface acr_req_if;
    logic                          valid;
    logic                          ready;
    logic [acr_pkg::START_W-1:0]   start_address;
    logic [acr_pkg::COUNT_W-1:0]   range_count;

    modport source (output valid, output start_address, output range_count, input ready);
    modport sink   (input valid, input start_address, input range_count, output ready);
endinterface

// File: design/acr_pfx_if.sv
`timescale 1ns / 1ps

interface acr_pfx_if;
    logic                          valid;
    logic                          ready;
    logic [acr_pkg::PADDR_W-1:0]   prefix_address;
    logic [acr_pkg::PLEN_W-1:0]    prefix_length;
    logic                          last;
    logic                          truncated;

    modport source (output valid, output prefix_address, output prefix_length,
                    output last, output truncated, input ready);
    modport sink   (input valid, input prefix_address, input prefix_length,
                    input last, input truncated, output ready);
endinterface

// File: design/address_range_to_cidr_prefixes_core.sv
`timescale 1ns / 1ps
// Channel   Role   Payload
// request   sink   start_address[31:0], range_count[30:0]
// prefix    source prefix_address[31:0], prefix_length[5:0], last, truncated
//
// A range is loaded first; then, for each prefix, the block is sized and then
// emitted into the output register.
// An empty range is taken without leaving idle and gives no transfer on prefix.
// Reset clears the controller state and the output valid.
// A stalled prefix holds the emit step; the next range can be taken while the
// final prefix of the previous one still waits in the output register.

module address_range_to_cidr_prefixes_core
#(
    parameter int unsigned ADDRESS_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    acr_req_if.sink    request,
    acr_pfx_if.source  prefix
);

    acr_pkg::ctrl_cmd_t  cmd;
    acr_pkg::dp_status_t status;

    acr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .status    (status),
        .cmd       (cmd)
    );

    acr_dpath
    #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    )
    u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .start_address  (request.start_address),
        .range_count    (request.range_count),
        .pfx_valid      (prefix.valid),
        .pfx_ready      (prefix.ready),
        .prefix_address (prefix.prefix_address),
        .prefix_length  (prefix.prefix_length),
        .last           (prefix.last),
        .truncated      (prefix.truncated)
    );

endmodule

// File: design/acr_ctrl.sv
`timescale 1ns / 1ps

module acr_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  acr_pkg::dp_status_t status,
    output acr_pkg::ctrl_cmd_t  cmd
);

    acr_pkg::state_t state_reg;
    acr_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            acr_pkg::ST_IDLE:
            begin
                if (req_valid && !status.count_zero)
                begin
                    state_next = acr_pkg::ST_CALC;
                end
            end
            acr_pkg::ST_CALC:
            begin
                state_next = acr_pkg::ST_STEP;
            end
            acr_pkg::ST_STEP:
            begin
                if (status.slot_free)
                begin
                    state_next = status.final_step ? acr_pkg::ST_IDLE : acr_pkg::ST_CALC;
                end
            end
            default:
            begin
                state_next = acr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            acr_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            acr_pkg::ST_CALC:
            begin
                cmd.calc = 1'b1;
            end
            acr_pkg::ST_STEP:
            begin
                cmd.step = status.slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: design/acr_dpath.sv
`timescale 1ns / 1ps

module acr_dpath
#(
    parameter int unsigned ADDRESS_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  acr_pkg::ctrl_cmd_t            cmd,
    output acr_pkg::dp_status_t           status,
    input  logic [acr_pkg::START_W-1:0]   start_address,
    input  logic [acr_pkg::COUNT_W-1:0]   range_count,
    output logic                          pfx_valid,
    input  logic                          pfx_ready,
    output logic [acr_pkg::PADDR_W-1:0]   prefix_address,
    output logic [acr_pkg::PLEN_W-1:0]    prefix_length,
    output logic                          last,
    output logic                          truncated
);

    localparam int unsigned AW  = ADDRESS_WIDTH;
    // common width for block sizes: whole space or remaining count
    localparam int unsigned CW  = (AW + 1 > acr_pkg::COUNT_W) ? AW + 1 : acr_pkg::COUNT_W;
    localparam int unsigned LGW = $clog2(CW);
    // wide enough for both the address and the 32-bit fields
    localparam int unsigned XW  = (AW > acr_pkg::PADDR_W) ? AW : acr_pkg::PADDR_W;

    logic [AW-1:0]                  addr_reg;
    logic [acr_pkg::COUNT_W-1:0]    rem_reg;
    logic [CW-1:0]                  block_reg;
    logic [LGW-1:0]                 lg_reg;
    logic [acr_pkg::RCNT_W-1:0]     rcnt_reg;

    logic                           out_valid_reg;
    logic [acr_pkg::PADDR_W-1:0]    out_addr_reg;
    logic [acr_pkg::PLEN_W-1:0]     out_len_reg;
    logic                           out_last_reg;
    logic                           out_trunc_reg;

    logic [XW-1:0]                  start_wide;
    logic [XW-1:0]                  addr_wide;
    logic [AW-1:0]                  low_bit;
    logic [AW:0]                    align_blk;
    logic [acr_pkg::COUNT_W-1:0]    smear;
    logic [acr_pkg::COUNT_W-1:0]    rem_top;
    logic [CW-1:0]                  align_ext;
    logic [CW-1:0]                  rem_ext;
    logic [CW-1:0]                  block_next;
    logic [LGW-1:0]                 lg_next;
    logic [AW:0]                    addr_sum;
    logic [acr_pkg::COUNT_W-1:0]    rem_next;
    logic                           wraps;
    logic                           slot_free;

    assign start_wide = XW'(start_address);
    assign addr_wide  = XW'(addr_reg);

    // Block sizing: aligned block of the address, capped by the remaining count
    always_comb
    begin
        low_bit   = addr_reg & (~addr_reg + AW'(1));
        align_blk = {(addr_reg == '0), low_bit};
        smear     = rem_reg;
        smear     = smear | (smear >> 1);
        smear     = smear | (smear >> 2);
        smear     = smear | (smear >> 4);
        smear     = smear | (smear >> 8);
        smear     = smear | (smear >> 16);
        rem_top   = smear ^ (smear >> 1);
        align_ext = CW'(align_blk);
        rem_ext   = CW'(rem_reg);
        block_next = (align_ext <= rem_ext) ? align_ext : CW'(rem_top);
    end

    // One-hot block size to log2
    always_comb
    begin
        lg_next = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (block_next[i])
            begin
                lg_next = lg_next | LGW'(i);
            end
        end
    end

    // Advance: block never exceeds the remaining count nor the whole space
    assign addr_sum = {1'b0, addr_reg} + block_reg[AW:0];
    assign wraps    = addr_sum[AW];
    assign rem_next = rem_reg - block_reg[acr_pkg::COUNT_W-1:0];

    assign slot_free = !out_valid_reg || pfx_ready;

    assign status.count_zero = (range_count == '0);
    assign status.slot_free  = slot_free;
    assign status.final_step = (rem_next == '0) || wraps
                             || (rcnt_reg == acr_pkg::RCNT_W'(acr_pkg::RESULT_LIMIT - 1));

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= start_wide[AW-1:0];
            rem_reg  <= range_count;
            rcnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            addr_reg <= addr_sum[AW-1:0];
            rem_reg  <= rem_next;
            rcnt_reg <= rcnt_reg + acr_pkg::RCNT_W'(1);
        end
        if (cmd.calc)
        begin
            block_reg <= block_next;
            lg_reg    <= lg_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pfx_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            out_addr_reg  <= addr_wide[acr_pkg::PADDR_W-1:0];
            out_len_reg   <= acr_pkg::PLEN_W'(AW) - acr_pkg::PLEN_W'(lg_reg);
            out_last_reg  <= status.final_step;
            out_trunc_reg <= wraps && (rem_next != '0);
        end
    end

    assign pfx_valid      = out_valid_reg;
    assign prefix_address = out_addr_reg;
    assign prefix_length  = out_len_reg;
    assign last           = out_last_reg;
    assign truncated      = out_trunc_reg;

endmodule

// File: dv/address_range_to_cidr_prefixes_checker.sv
`timescale 1ns / 1ps

module address_range_to_cidr_prefixes_checker
    import acr_pkg::*;
#(
    parameter int unsigned ADDRESS_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    acr_req_if          request,
    acr_pfx_if          prefix,
    output int unsigned outstanding,
    output int unsigned mismatches
);

    typedef struct packed {
        logic [PADDR_W-1:0] base;
        logic [PLEN_W-1:0]  len;
        logic               last;
        logic               truncated;
    } cidr_prefix_t;

    cidr_prefix_t expected_prefixes[$];
    int unsigned  n_waiting = 0;
    int unsigned  n_bad     = 0;

    assign outstanding = n_waiting;
    assign mismatches  = n_bad;

    // Split one range into aligned blocks, largest first at each address
    function automatic void decompose_range(input logic [START_W-1:0] start,
                                            input logic [COUNT_W-1:0] count);
        logic [63:0]  space;
        logic [63:0]  amask;
        logic [63:0]  addr;
        logic [63:0]  left;
        logic [63:0]  blk;
        int unsigned  log_size;
        int unsigned  n;
        bit           wraps;
        bit           done;
        cidr_prefix_t p;
        space = 64'd1 << ADDRESS_WIDTH;
        amask = space - 64'd1;
        addr  = {32'd0, start} & amask;
        left  = {33'd0, count};
        n     = 0;
        done  = 1'b0;
        while (left != 64'd0 && n < RESULT_LIMIT && !done)
        begin
            // lowest set bit of the address, whole space at zero
            blk = addr & ((~addr + 64'd1) & amask);
            if (blk == 64'd0)
                blk = space;
            while (blk > left)
                blk = blk >> 1;
            log_size = 0;
            while ((64'd1 << log_size) < blk)
                log_size++;
            wraps = (addr + blk) >= space;
            left  = left - blk;
            done  = (left == 64'd0) || wraps || (n == RESULT_LIMIT - 1);
            p.base      = addr[PADDR_W-1:0];
            p.len       = PLEN_W'(ADDRESS_WIDTH - log_size);
            p.last      = done;
            p.truncated = wraps && (left != 64'd0);
            expected_prefixes.insert(expected_prefixes.size(), p);
            n++;
            addr = (addr + blk) & amask;
        end
    endfunction

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v)
        begin
            n_bad++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Record each range transfer, compare each prefix transfer in order
    always @(posedge clk)
    begin
        cidr_prefix_t want;
        if (rst_n)
        begin
            if (request.valid && request.ready)
                decompose_range(request.start_address, request.range_count);
            if (prefix.valid && prefix.ready)
            begin
                if (expected_prefixes.size() == 0)
                begin
                    n_bad++;
                    $display("%0t: unexpected prefix, expected none actual %0h/%0d %s%0b %s%0b",
                             $time, prefix.prefix_address, prefix.prefix_length,
                             "last=", prefix.last, "trunc=", prefix.truncated);
                end
                else
                begin
                    want = expected_prefixes.pop_front();
                    check_field("prefix_address", want.base, prefix.prefix_address);
                    check_field("prefix_length", want.len, prefix.prefix_length);
                    check_field("last", want.last, prefix.last);
                    check_field("truncated", want.truncated, prefix.truncated);
                end
            end
            n_waiting = expected_prefixes.size();
        end
    end

endmodule

// File: dv/address_range_to_cidr_prefixes_core_tb.sv
`timescale 1ns / 1ps

module address_range_to_cidr_prefixes_core_tb;
    import acr_pkg::*;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned RANDOM_RUNS = 480;
    localparam int unsigned DRAIN_CYC   = 2 * RESULT_LIMIT + 8;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_HALF,
        RX_SLOW,
        RX_BUSY
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned outstanding;
    int unsigned mismatches;
    int unsigned burst_left = 0;
    int unsigned rx_left    = 0;
    rx_mode_t    rx_mode    = RX_FREE;

    acr_req_if req_ch();
    acr_pfx_if pfx_ch();

    address_range_to_cidr_prefixes_core #(
        .ADDRESS_WIDTH (ADDR_W)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .prefix  (pfx_ch)
    );

    address_range_to_cidr_prefixes_checker #(
        .ADDRESS_WIDTH (ADDR_W)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (req_ch),
        .prefix      (pfx_ch),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always #5 clk = ~clk;

    // Receiver: stall pattern switches between modes of random length
    initial pfx_ch.ready = 1'b0;

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(4, 60);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE: pfx_ch.ready <= 1'b1;
            RX_HALF: pfx_ch.ready <= $urandom_range(0, 1);
            RX_SLOW: pfx_ch.ready <= ($urandom_range(0, 3) == 0);
            default: pfx_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // One range transfer; valid stays up inside a burst, drops between bursts
    task automatic push_range(input logic [START_W-1:0] start,
                              input logic [COUNT_W-1:0] count);
        int unsigned gap;
        req_ch.valid         <= 1'b1;
        req_ch.start_address <= start;
        req_ch.range_count   <= count;
        do @(posedge clk); while (!req_ch.ready);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 10);
            req_ch.valid         <= 1'b0;
            req_ch.start_address <= $urandom;
            req_ch.range_count   <= COUNT_W'($urandom);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // Hold the sender until every prefix so far has come out
    task automatic wait_all_prefixes();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    function automatic logic [START_W-1:0] pick_start();
        int unsigned kind;
        kind = $urandom_range(0, 5);
        case (kind)
            0: return $urandom & (32'hFFFF_FFFF << $urandom_range(0, 31));
            1: return 32'hFFFF_FFFF - $urandom_range(0, 4095);
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Count with a random number of significant bits
    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned nbits;
        nbits = $urandom_range(0, 31);
        return COUNT_W'({32'd0, $urandom} >> (32 - nbits));
    endfunction

    // Stimulus
    initial
    begin
        int unsigned  n_ranges;
        logic [COUNT_W-1:0] cnt;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.start_address = '0;
        req_ch.range_count   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ranges
        push_range(32'h0000_0000, 31'd0);
        push_range(32'hFFFF_FFFF, 31'd0);
        // single addresses, at the bottom and at the top
        push_range(32'h0000_0000, 31'd1);
        push_range(32'hFFFF_FFFF, 31'd1);
        // up to and past the top of the address space
        push_range(32'hFFFF_FFFF, 31'd2);
        push_range(32'hFFFF_FF00, 31'd256);
        push_range(32'hFFFF_FF00, 31'd300);
        push_range(32'hFFFF_FFFF, 31'h7FFF_FFFF);
        push_range(32'hC000_0000, 31'h4000_0000);
        push_range(32'hC000_0001, 31'h4000_0000);
        // largest counts, up to the longest runs of prefixes
        push_range(32'h0000_0000, 31'h7FFF_FFFF);
        push_range(32'h0000_0001, 31'h7FFF_FFFF);
        push_range(32'h0000_0001, 31'h7FFF_FFFE);
        push_range(32'hAAAA_AAAB, 31'h7FFF_FFFF);
        push_range(32'h8000_0000, 31'h7FFF_FFFF);
        push_range(32'h0000_0000, 31'h4000_0000);
        // ordinary aligned and unaligned ranges
        push_range(32'h0A00_0000, 31'd256);
        push_range(32'h0A00_0001, 31'd255);
        push_range(32'hC0A8_0001, 31'd254);
        push_range(32'h5555_5555, 31'd1000);
        push_range(32'h7FFF_FFFF, 31'd2);
        wait_all_prefixes();

        // random ranges; empty ones are not counted
        n_ranges = 0;
        while (n_ranges < RANDOM_RUNS)
        begin
            cnt = pick_count();
            push_range(pick_start(), cnt);
            if (cnt != '0)
                n_ranges++;
            if (n_ranges == RANDOM_RUNS / 2 && cnt != '0)
                wait_all_prefixes();
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYC) @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
